// File: rtl/core/plsp_pkg.sv
// Package for the polyline station/lateral projection block.
// Types, codes and widths shared by plsp_ctrl, plsp_dp and the top level.
// No dependencies.
package plsp_pkg;

    localparam int MAX_POINTS_DEF = 256;
    localparam int COORD_W        = 24;
    localparam int DIV_Q_W        = 28;
    localparam int DIV_CNT_W      = $clog2(DIV_Q_W + 1);
    localparam logic [3:0] MUL_LAST_STEP = 4'd10;

    localparam logic [1:0] CMD_CLEAR   = 2'd0;
    localparam logic [1:0] CMD_APPEND  = 2'd1;
    localparam logic [1:0] CMD_PROJECT = 2'd2;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_NO_SEG = 2'd1;
    localparam logic [1:0] STAT_FULL   = 2'd2;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_CLEAR,
        OP_APPEND_WR,
        OP_RD_PREV,
        OP_LOAD_APP,
        OP_RD_A0,
        OP_LOAD_A,
        OP_RD_B,
        OP_LOAD_B,
        OP_SUBS,
        OP_MUL,
        OP_SQ_INIT,
        OP_SQ_STEP,
        OP_SQ_END,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_END,
        OP_ZERO_PP,
        OP_PP,
        OP_EVAL,
        OP_RD_BEST,
        OP_OUT
    } dp_op_t;

    typedef enum logic [1:0] {
        KIND_OK,
        KIND_NOSEG,
        KIND_FULL,
        KIND_PROJ
    } out_kind_t;

    typedef struct packed {
        dp_op_t    op;
        logic [3:0] step;
        logic      sel;
        out_kind_t kind;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] cmd_code;
        logic       count_zero;
        logic       count_full;
        logic       count_lt2;
        logic       sq_done;
        logic       dv_done;
        logic       len_zero;
        logic       last_seg;
    } dp_stat_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_APP_LOAD,
        S_APP_WR,
        S_LOAD_A,
        S_RD_B,
        S_LOAD_B,
        S_SUBS,
        S_MUL,
        S_SQ_INIT,
        S_SQ_RUN,
        S_SQ_END,
        S_DIV_CHK,
        S_DIV_INIT,
        S_DIV_RUN,
        S_DIV_END,
        S_PP,
        S_EVAL,
        S_RD_BEST,
        S_DONE
    } ctrl_state_t;

endpackage

// File: rtl/core/plsp_ctrl.sv
// Sequencer for the polyline projection block.
// Walks append and project commands through plsp_dp; depends on plsp_pkg.
module plsp_ctrl
    import plsp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    ctrl_state_t state_reg, state_next;
    logic [3:0]  step_reg, step_next;
    logic        app_reg, app_next;
    logic        fin_reg, fin_next;
    logic        dsel_reg, dsel_next;
    out_kind_t   kind_reg, kind_next;
    logic        m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            step_reg    <= '0;
            app_reg     <= 1'b0;
            fin_reg     <= 1'b0;
            dsel_reg    <= 1'b0;
            kind_reg    <= KIND_OK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            app_reg     <= app_next;
            fin_reg     <= fin_next;
            dsel_reg    <= dsel_next;
            kind_reg    <= kind_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        app_next     = app_reg;
        fin_next     = fin_reg;
        dsel_next    = dsel_reg;
        kind_next    = kind_reg;
        m_valid_next = m_valid_reg && !m_tready;
        cmd.op       = OP_NONE;
        cmd.step     = step_reg;
        cmd.sel      = 1'b0;
        cmd.kind     = kind_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = OP_LATCH;
                    fin_next   = 1'b0;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (stat.cmd_code)
                    CMD_CLEAR: begin
                        cmd.op     = OP_CLEAR;
                        kind_next  = KIND_OK;
                        state_next = S_DONE;
                    end
                    CMD_APPEND: begin
                        app_next = 1'b1;
                        if (stat.count_full) begin
                            kind_next  = KIND_FULL;
                            state_next = S_DONE;
                        end else if (stat.count_zero) begin
                            cmd.op     = OP_APPEND_WR;
                            kind_next  = KIND_OK;
                            state_next = S_DONE;
                        end else begin
                            cmd.op     = OP_RD_PREV;
                            state_next = S_APP_LOAD;
                        end
                    end
                    CMD_PROJECT: begin
                        app_next = 1'b0;
                        if (stat.count_lt2) begin
                            kind_next  = KIND_NOSEG;
                            state_next = S_DONE;
                        end else begin
                            cmd.op     = OP_RD_A0;
                            state_next = S_LOAD_A;
                        end
                    end
                    default: begin
                        kind_next  = KIND_OK;
                        state_next = S_DONE;
                    end
                endcase
            end
            S_APP_LOAD: begin
                cmd.op     = OP_LOAD_APP;
                state_next = S_SUBS;
            end
            S_APP_WR: begin
                cmd.op     = OP_APPEND_WR;
                kind_next  = KIND_OK;
                state_next = S_DONE;
            end
            S_LOAD_A: begin
                cmd.op     = OP_LOAD_A;
                state_next = S_RD_B;
            end
            S_RD_B: begin
                cmd.op     = OP_RD_B;
                state_next = S_LOAD_B;
            end
            S_LOAD_B: begin
                cmd.op     = OP_LOAD_B;
                state_next = S_SUBS;
            end
            S_SUBS: begin
                cmd.op     = OP_SUBS;
                step_next  = '0;
                state_next = S_MUL;
            end
            S_MUL: begin
                cmd.op = OP_MUL;
                if (step_reg == MUL_LAST_STEP) begin
                    state_next = S_SQ_INIT;
                end else begin
                    step_next = step_reg + 4'd1;
                end
            end
            S_SQ_INIT: begin
                cmd.op     = OP_SQ_INIT;
                cmd.sel    = fin_reg;
                state_next = S_SQ_RUN;
            end
            S_SQ_RUN: begin
                if (stat.sq_done) begin
                    state_next = S_SQ_END;
                end else begin
                    cmd.op = OP_SQ_STEP;
                end
            end
            S_SQ_END: begin
                cmd.op  = OP_SQ_END;
                cmd.sel = fin_reg;
                if (fin_reg) begin
                    state_next = S_RD_BEST;
                end else if (app_reg) begin
                    state_next = S_APP_WR;
                end else begin
                    state_next = S_DIV_CHK;
                end
            end
            S_DIV_CHK: begin
                if (stat.len_zero) begin
                    cmd.op     = OP_ZERO_PP;
                    state_next = S_PP;
                end else begin
                    dsel_next  = 1'b0;
                    state_next = S_DIV_INIT;
                end
            end
            S_DIV_INIT: begin
                cmd.op     = OP_DIV_INIT;
                cmd.sel    = dsel_reg;
                state_next = S_DIV_RUN;
            end
            S_DIV_RUN: begin
                if (stat.dv_done) begin
                    state_next = S_DIV_END;
                end else begin
                    cmd.op = OP_DIV_STEP;
                end
            end
            S_DIV_END: begin
                cmd.op  = OP_DIV_END;
                cmd.sel = dsel_reg;
                if (dsel_reg) begin
                    state_next = S_PP;
                end else begin
                    dsel_next  = 1'b1;
                    state_next = S_DIV_INIT;
                end
            end
            S_PP: begin
                cmd.op     = OP_PP;
                state_next = S_EVAL;
            end
            S_EVAL: begin
                cmd.op = OP_EVAL;
                if (stat.last_seg) begin
                    fin_next   = 1'b1;
                    state_next = S_SQ_INIT;
                end else begin
                    state_next = S_RD_B;
                end
            end
            S_RD_BEST: begin
                cmd.op     = OP_RD_BEST;
                kind_next  = KIND_PROJ;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.op       = OP_OUT;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/plsp_dp.sv
// Datapath for the polyline projection block: vertex tables, shared
// multiplier, bit-serial square root and divider, best-segment tracking.
// Depends on plsp_pkg.
module plsp_dp
    import plsp_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [1:0]                in_command,
    input  logic signed [COORD_W-1:0] in_x,
    input  logic signed [COORD_W-1:0] in_y,
    input  dp_cmd_t                   cmd,
    output dp_stat_t                  stat,
    output logic [1:0]                out_status,
    output logic [31:0]               out_station,
    output logic [31:0]               out_lateral,
    output logic [30:0]               out_distance,
    output logic [7:0]                out_segment
);

    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    function automatic logic signed [28:0] ext29(input logic signed [24:0] v);
        return {{4{v[24]}}, v};
    endfunction

    logic [1:0]                cmd_code_reg;
    logic signed [COORD_W-1:0] px_reg, py_reg, ax_reg, ay_reg, bx_reg, by_reg;
    logic [CW-1:0]             count_reg;
    logic [IW-1:0]             seg_reg, best_reg;

    logic signed [COORD_W-1:0] mem_x [MAX_POINTS];
    logic signed [COORD_W-1:0] mem_y [MAX_POINTS];
    logic [31:0]               mem_c [MAX_POINTS];
    logic signed [COORD_W-1:0] rd_x_reg, rd_y_reg;
    logic [31:0]               rd_c_reg;
    logic [31:0]               cum_prev_reg;

    logic signed [24:0] dx_reg, dy_reg, vx_reg, vy_reg, wx_reg, wy_reg;
    logic signed [57:0] mul_reg;
    logic signed [51:0] len2_reg, dot_reg, cross_reg, da_reg, db_reg;

    logic [53:0] sq_v_reg, sq_r_reg, sq_bit_reg;
    logic [26:0] len_reg, dist_reg;

    logic [DIV_Q_W-1:0]   dv_n_reg, dv_rem_reg, dv_q_reg, dv_d_reg;
    logic [DIV_CNT_W-1:0] dv_cnt_reg;
    logic                 dv_neg_reg;

    logic signed [28:0] proj_reg, prod_reg, best_proj_reg, best_prod_reg;
    logic [53:0]        best_d2_reg;
    logic [26:0]        best_len_reg;

    logic [1:0]  out_status_reg;
    logic [31:0] out_station_reg, out_lateral_reg;
    logic [30:0] out_distance_reg;
    logic [7:0]  out_segment_reg;

    // memory ports
    logic          rd_en, wr_en;
    logic [IW-1:0] rd_addr, wr_addr;
    logic [32:0]   cum_sum;
    logic [31:0]   wr_cum;

    assign wr_addr = count_reg[IW-1:0];
    assign wr_en   = (cmd.op == OP_APPEND_WR);
    assign cum_sum = {1'b0, cum_prev_reg} + 33'(len_reg);
    assign wr_cum  = (count_reg == '0) ? 32'd0 :
                     (cum_sum > 33'h07FFFFFFF) ? 32'h7FFFFFFF : cum_sum[31:0];

    always_comb begin
        rd_en   = 1'b1;
        rd_addr = best_reg;
        case (cmd.op)
            OP_RD_PREV: rd_addr = IW'(count_reg - CW'(1));
            OP_RD_A0:   rd_addr = '0;
            OP_RD_B:    rd_addr = seg_reg + IW'(1);
            OP_RD_BEST: rd_addr = best_reg;
            default:    rd_en   = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_x[wr_addr] <= px_reg;
            mem_y[wr_addr] <= py_reg;
            mem_c[wr_addr] <= wr_cum;
        end
        if (rd_en) begin
            rd_x_reg <= mem_x[rd_addr];
            rd_y_reg <= mem_y[rd_addr];
            rd_c_reg <= mem_c[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.op == OP_CLEAR) begin
            count_reg <= '0;
        end else if (wr_en) begin
            count_reg <= count_reg + CW'(1);
        end
    end

    // shared multiplier
    logic signed [28:0] mul_a, mul_b;
    logic signed [51:0] mul_lo;

    assign mul_lo = mul_reg[51:0];

    always_comb begin
        mul_a = ext29(dx_reg);
        mul_b = ext29(dx_reg);
        if (cmd.op == OP_PP) begin
            mul_a = prod_reg;
            mul_b = prod_reg;
        end else begin
            case (cmd.step)
                4'd1: begin mul_a = ext29(dy_reg); mul_b = ext29(dy_reg); end
                4'd2: begin mul_a = ext29(dx_reg); mul_b = ext29(vx_reg); end
                4'd3: begin mul_a = ext29(dy_reg); mul_b = ext29(vy_reg); end
                4'd4: begin mul_a = ext29(dx_reg); mul_b = ext29(vy_reg); end
                4'd5: begin mul_a = ext29(dy_reg); mul_b = ext29(vx_reg); end
                4'd6: begin mul_a = ext29(vx_reg); mul_b = ext29(vx_reg); end
                4'd7: begin mul_a = ext29(vy_reg); mul_b = ext29(vy_reg); end
                4'd8: begin mul_a = ext29(wx_reg); mul_b = ext29(wx_reg); end
                4'd9: begin mul_a = ext29(wy_reg); mul_b = ext29(wy_reg); end
                default: begin mul_a = ext29(dx_reg); mul_b = ext29(dx_reg); end
            endcase
        end
    end

    // square root step
    logic [53:0] sq_trial, sq_root;
    assign sq_trial = sq_r_reg + sq_bit_reg;
    assign sq_root  = (sq_v_reg > sq_r_reg) ? sq_r_reg + 54'd1 : sq_r_reg;

    // divider setup and step
    logic signed [51:0] dv_num;
    logic [51:0]        dv_mag;
    logic [55:0]        dv_big;
    logic [DIV_Q_W:0]   dv_sh;
    logic               dv_bit;
    logic signed [28:0] dv_res;

    assign dv_num = cmd.sel ? cross_reg : dot_reg;
    assign dv_mag = (dv_num < 0) ? 52'(-dv_num) : 52'(dv_num);
    assign dv_big = 56'({dv_mag, 1'b0}) + 56'(len_reg);
    assign dv_sh  = {dv_rem_reg, dv_n_reg[DIV_Q_W-1]};
    assign dv_bit = (dv_sh >= {1'b0, dv_d_reg});
    assign dv_res = dv_neg_reg ? -$signed({1'b0, dv_q_reg}) : $signed({1'b0, dv_q_reg});

    // candidate squared distance
    logic [53:0] d2;
    always_comb begin
        if (len2_reg == 52'sd0 || dot_reg <= 52'sd0) begin
            d2 = {2'b00, da_reg};
        end else if (dot_reg >= len2_reg) begin
            d2 = {2'b00, db_reg};
        end else begin
            d2 = mul_reg[53:0];
        end
    end

    // station and lateral of the chosen segment
    logic               fin_first, fin_last;
    logic signed [28:0] dist_s, len_s, sgn_dist, lat;
    logic signed [33:0] cum_s, st;
    logic [31:0]        st_sat;

    assign fin_first = (best_reg == '0);
    assign fin_last  = (CW'(best_reg) + CW'(2) == count_reg);
    assign dist_s    = $signed({2'b00, dist_reg});
    assign len_s     = $signed({2'b00, best_len_reg});
    assign sgn_dist  = (best_prod_reg > 29'sd0) ? dist_s : -dist_s;
    assign cum_s     = $signed({2'b00, rd_c_reg});

    always_comb begin
        if (fin_first) begin
            st  = 34'((best_proj_reg < len_s) ? best_proj_reg : len_s);
            lat = (best_proj_reg < 29'sd0) ? best_prod_reg : sgn_dist;
        end else if (fin_last) begin
            st  = cum_s + 34'((best_proj_reg > 29'sd0) ? best_proj_reg : 29'sd0);
            lat = (best_proj_reg > 29'sd0) ? best_prod_reg : sgn_dist;
        end else begin
            if (best_proj_reg < 29'sd0) begin
                st = cum_s;
            end else if (best_proj_reg > len_s) begin
                st = cum_s + 34'(len_s);
            end else begin
                st = cum_s + 34'(best_proj_reg);
            end
            lat = sgn_dist;
        end
        if (st > 34'sh07FFFFFFF) begin
            st_sat = 32'h7FFFFFFF;
        end else if (st < -34'sh080000000) begin
            st_sat = 32'h80000000;
        end else begin
            st_sat = st[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LATCH: begin
                cmd_code_reg <= in_command;
                px_reg       <= in_x;
                py_reg       <= in_y;
            end
            OP_LOAD_APP: begin
                ax_reg       <= rd_x_reg;
                ay_reg       <= rd_y_reg;
                bx_reg       <= px_reg;
                by_reg       <= py_reg;
                cum_prev_reg <= rd_c_reg;
            end
            OP_RD_A0: begin
                seg_reg <= '0;
            end
            OP_LOAD_A: begin
                ax_reg <= rd_x_reg;
                ay_reg <= rd_y_reg;
            end
            OP_LOAD_B: begin
                bx_reg <= rd_x_reg;
                by_reg <= rd_y_reg;
            end
            OP_SUBS: begin
                dx_reg <= {bx_reg[23], bx_reg} - {ax_reg[23], ax_reg};
                dy_reg <= {by_reg[23], by_reg} - {ay_reg[23], ay_reg};
                vx_reg <= {px_reg[23], px_reg} - {ax_reg[23], ax_reg};
                vy_reg <= {py_reg[23], py_reg} - {ay_reg[23], ay_reg};
                wx_reg <= {px_reg[23], px_reg} - {bx_reg[23], bx_reg};
                wy_reg <= {py_reg[23], py_reg} - {by_reg[23], by_reg};
            end
            OP_MUL: begin
                mul_reg <= mul_a * mul_b;
                case (cmd.step)
                    4'd1:    len2_reg  <= mul_lo;
                    4'd2:    len2_reg  <= len2_reg + mul_lo;
                    4'd3:    dot_reg   <= mul_lo;
                    4'd4:    dot_reg   <= dot_reg + mul_lo;
                    4'd5:    cross_reg <= mul_lo;
                    4'd6:    cross_reg <= cross_reg - mul_lo;
                    4'd7:    da_reg    <= mul_lo;
                    4'd8:    da_reg    <= da_reg + mul_lo;
                    4'd9:    db_reg    <= mul_lo;
                    4'd10:   db_reg    <= db_reg + mul_lo;
                    default: ;
                endcase
            end
            OP_SQ_INIT: begin
                sq_v_reg   <= cmd.sel ? best_d2_reg : {2'b00, len2_reg};
                sq_r_reg   <= '0;
                sq_bit_reg <= {2'b01, 52'd0};
            end
            OP_SQ_STEP: begin
                if (sq_v_reg >= sq_trial) begin
                    sq_v_reg <= sq_v_reg - sq_trial;
                    sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
                end else begin
                    sq_r_reg <= sq_r_reg >> 1;
                end
                sq_bit_reg <= sq_bit_reg >> 2;
            end
            OP_SQ_END: begin
                if (cmd.sel) begin
                    dist_reg <= sq_root[26:0];
                end else begin
                    len_reg <= sq_root[26:0];
                end
            end
            OP_DIV_INIT: begin
                dv_neg_reg <= (dv_num < 0);
                dv_rem_reg <= dv_big[55:DIV_Q_W];
                dv_n_reg   <= dv_big[DIV_Q_W-1:0];
                dv_d_reg   <= {len_reg, 1'b0};
                dv_q_reg   <= '0;
                dv_cnt_reg <= '0;
            end
            OP_DIV_STEP: begin
                dv_rem_reg <= dv_bit ? DIV_Q_W'(dv_sh - {1'b0, dv_d_reg})
                                     : dv_sh[DIV_Q_W-1:0];
                dv_n_reg   <= dv_n_reg << 1;
                dv_q_reg   <= {dv_q_reg[DIV_Q_W-2:0], dv_bit};
                dv_cnt_reg <= dv_cnt_reg + DIV_CNT_W'(1);
            end
            OP_DIV_END: begin
                if (cmd.sel) begin
                    prod_reg <= dv_res;
                end else begin
                    proj_reg <= dv_res;
                end
            end
            OP_ZERO_PP: begin
                proj_reg <= '0;
                prod_reg <= '0;
            end
            OP_PP: begin
                mul_reg <= mul_a * mul_b;
            end
            OP_EVAL: begin
                if (seg_reg == '0 || d2 < best_d2_reg) begin
                    best_reg      <= seg_reg;
                    best_d2_reg   <= d2;
                    best_proj_reg <= proj_reg;
                    best_prod_reg <= prod_reg;
                    best_len_reg  <= len_reg;
                end
                ax_reg  <= bx_reg;
                ay_reg  <= by_reg;
                seg_reg <= seg_reg + IW'(1);
            end
            OP_OUT: begin
                out_station_reg  <= '0;
                out_lateral_reg  <= '0;
                out_distance_reg <= '0;
                out_segment_reg  <= '0;
                case (cmd.kind)
                    KIND_NOSEG: out_status_reg <= STAT_NO_SEG;
                    KIND_FULL:  out_status_reg <= STAT_FULL;
                    KIND_PROJ: begin
                        out_status_reg   <= STAT_OK;
                        out_station_reg  <= st_sat;
                        out_lateral_reg  <= 32'(lat);
                        out_distance_reg <= 31'(dist_reg);
                        out_segment_reg  <= 8'(best_reg);
                    end
                    default:    out_status_reg <= STAT_OK;
                endcase
            end
            default: ;
        endcase
    end

    assign stat.cmd_code   = cmd_code_reg;
    assign stat.count_zero = (count_reg == '0);
    assign stat.count_full = (count_reg == CW'(MAX_POINTS));
    assign stat.count_lt2  = (count_reg < CW'(2));
    assign stat.sq_done    = (sq_bit_reg == '0);
    assign stat.dv_done    = (dv_cnt_reg == DIV_CNT_W'(DIV_Q_W));
    assign stat.len_zero   = (len_reg == '0);
    assign stat.last_seg   = (CW'(seg_reg) + CW'(2) == count_reg);

    assign out_status   = out_status_reg;
    assign out_station  = out_station_reg;
    assign out_lateral  = out_lateral_reg;
    assign out_distance = out_distance_reg;
    assign out_segment  = out_segment_reg;

endmodule

// File: rtl/core/polyline_station_lateral_projection_top.sv
// Clear and status-only items go straight to the output stage; an append computes
// one segment length (11 multiplier steps and a 27-step square root).
// Project: for each stored segment the shared multiplier, the 27-step square root
// and two 28-step dividers, then a final square root for the distance to finish.
// One item at a time; the next item is taken while a result waits in the output register.
// Reset (aresetn low, synchronous) empties the polyline; vertex tables are not cleared.
module polyline_station_lateral_projection_top
    import plsp_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,   // coord_x [23:0], coord_y [47:24]
    input  logic [1:0]   s_tuser,   // command [1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // station [31:0], lateral_offset [63:32],
                                    // distance [94:64], segment_index [102:95]
    output logic [1:0]   m_tuser    // status [1:0]
);

    dp_cmd_t     cmd;
    dp_stat_t    stat;
    logic [31:0] station, lateral_offset;
    logic [30:0] distance;
    logic [7:0]  segment_index;

    plsp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    plsp_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_command   (s_tuser),
        .in_x         (s_tdata[23:0]),
        .in_y         (s_tdata[47:24]),
        .cmd          (cmd),
        .stat         (stat),
        .out_status   (m_tuser),
        .out_station  (station),
        .out_lateral  (lateral_offset),
        .out_distance (distance),
        .out_segment  (segment_index)
    );

    assign m_tdata = {1'b0, segment_index, distance, lateral_offset, station};

endmodule

// File: dv/polyline_station_lateral_projection_top_test.sv
// Testbench for polyline_station_lateral_projection_top: a queue-fed stream driver,
// a result monitor and a bit-accurate projection predictor checked item by item.
// Depends on plsp_pkg and the top level of the block.
`timescale 1ns / 100ps

module polyline_station_lateral_projection_top_test;
    import plsp_pkg::*;

    localparam int NPTS = 256;
    localparam int QUIET_LIMIT = 400000;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [23:0] y;
        logic [23:0] x;
    } cmd_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] station;
        logic [31:0] lateral;
        logic [30:0] distance;
        logic [7:0]  seg;
    } proj_res_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [47:0]  s_tdata = '0;   // coord_x [23:0], coord_y [47:24]
    logic [1:0]   s_tuser = '0;   // command [1:0]
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;        // station, lateral_offset, distance, segment_index
    logic [1:0]   m_tuser;        // status

    cmd_item_t pending_items[$];
    proj_res_t expected_results[$];
    int        total_items = 0;
    int        items_sent = 0;
    int        errors = 0;
    int        quiet_cycles = 0;

    longint    poly_x[NPTS];
    longint    poly_y[NPTS];
    longint    arc_len[NPTS];
    int        poly_count = 0;

    polyline_station_lateral_projection_top dut (.*);

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic longint unsigned sqrt_rnd(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        if (v > r) r++;
        return r;
    endfunction

    function automatic longint div_rnd(longint num, longint unsigned den);
        longint unsigned mag;
        longint unsigned q;
        mag = (num < 0) ? longint'(-num) : num;
        q = (2 * mag + den) / (2 * den);
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic proj_res_t project_point(logic [1:0] cmd, logic [23:0] cx,
                                                logic [23:0] cy);
        proj_res_t r;
        longint px, py, ax, ay, dx, dy, vx, vy, wx, wy, len2, dot, crs, pj, pd;
        longint best_pj, best_pd, best_len, dist_q, sd, s, l, c;
        longint unsigned len, d2, best_d2;
        int nseg, best;
        r = '0;
        px = longint'($signed(cx));
        py = longint'($signed(cy));
        best_d2 = 0; best_pj = 0; best_pd = 0; best_len = 0; best = 0;
        if (cmd == CMD_CLEAR) begin
            poly_count = 0;
        end else if (cmd == CMD_APPEND) begin
            if (poly_count >= NPTS) begin
                r.status = STAT_FULL;
            end else begin
                poly_x[poly_count] = px;
                poly_y[poly_count] = py;
                if (poly_count == 0) begin
                    arc_len[0] = 0;
                end else begin
                    dx = px - poly_x[poly_count-1];
                    dy = py - poly_y[poly_count-1];
                    c = arc_len[poly_count-1] + longint'(sqrt_rnd(dx*dx + dy*dy));
                    arc_len[poly_count] = (c > 64'sd2147483647) ? 64'sd2147483647 : c;
                end
                poly_count++;
            end
        end else if (cmd == CMD_PROJECT) begin
            if (poly_count < 2) begin
                r.status = STAT_NO_SEG;
            end else begin
                nseg = poly_count - 1;
                for (int i = 0; i < nseg; i++) begin
                    ax = poly_x[i]; ay = poly_y[i];
                    dx = poly_x[i+1] - ax; dy = poly_y[i+1] - ay;
                    vx = px - ax; vy = py - ay;
                    wx = px - poly_x[i+1]; wy = py - poly_y[i+1];
                    len2 = dx*dx + dy*dy;
                    dot = dx*vx + dy*vy;
                    crs = dx*vy - dy*vx;
                    len = sqrt_rnd(len2);
                    pj = 0; pd = 0;
                    if (len != 0) begin
                        pj = div_rnd(dot, len);
                        pd = div_rnd(crs, len);
                    end
                    if (len2 == 0 || dot <= 0) d2 = vx*vx + vy*vy;
                    else if (dot >= len2) d2 = wx*wx + wy*wy;
                    else d2 = pd*pd;
                    if (i == 0 || d2 < best_d2) begin
                        best = i; best_d2 = d2; best_pj = pj; best_pd = pd;
                        best_len = len;
                    end
                end
                dist_q = sqrt_rnd(best_d2);
                sd = (best_pd > 0) ? dist_q : -dist_q;
                if (best == 0) begin
                    s = (best_pj < best_len) ? best_pj : best_len;
                    l = (best_pj < 0) ? best_pd : sd;
                end else if (best == nseg - 1) begin
                    s = arc_len[best] + ((best_pj > 0) ? best_pj : 0);
                    l = (best_pj > 0) ? best_pd : sd;
                end else begin
                    c = (best_pj < 0) ? 0 : ((best_pj > best_len) ? best_len : best_pj);
                    s = arc_len[best] + c;
                    l = sd;
                end
                r.station  = 32'(sat32(s));
                r.lateral  = 32'(sat32(l));
                r.distance = 31'(dist_q);
                r.seg      = 8'(best);
            end
        end
        return r;
    endfunction

    task automatic push_cmd(logic [1:0] cmd, longint x, longint y);
        cmd_item_t it;
        it.cmd = cmd;
        it.x = 24'(x);
        it.y = 24'(y);
        pending_items.push_back(it);
    endtask

    function automatic longint near(longint ctr, int spread);
        return ctr + longint'($urandom_range(0, 2*spread)) - spread;
    endfunction

    function automatic longint any_coord();
        return longint'($signed(24'($urandom)));
    endfunction

    // Phase 0: sender idles 13%, receiver 69%; phase 1 swapped; phase 2 none.
    function automatic bit idle_roll(bit sender);
        int ph;
        ph = (total_items == 0) ? 0 : (items_sent * 3) / total_items;
        if (ph == 0) return $urandom_range(0, 99) < (sender ? 13 : 69);
        if (ph == 1) return $urandom_range(0, 99) < (sender ? 69 : 13);
        return 1'b0;
    endfunction

    always @(posedge aclk) begin
        cmd_item_t it;
        logic      nxt_valid;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(project_point(s_tuser, s_tdata[23:0],
                                                         s_tdata[47:24]));
                items_sent++;
            end
            nxt_valid = s_tvalid && !s_tready;
            if (!nxt_valid && pending_items.size() != 0 && !idle_roll(1'b1)) begin
                it = pending_items.pop_front();
                s_tdata <= {it.y, it.x};
                s_tuser <= it.cmd;
                nxt_valid = 1'b1;
            end
            s_tvalid <= nxt_valid;
        end
    end

    always @(posedge aclk) begin
        proj_res_t got;
        proj_res_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser, m_tdata[31:0], m_tdata[63:32], m_tdata[94:64], m_tdata[102:95]};
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result item %h", got);
            end else begin
                exp_r = expected_results.pop_front();
                if (got.status !== exp_r.status || got.station !== exp_r.station ||
                    got.lateral !== exp_r.lateral || got.distance !== exp_r.distance ||
                    got.seg !== exp_r.seg) begin
                    errors++;
                    if (errors <= 10)
                        $display("bad item: exp st=%0d s=%0d l=%0d d=%0d i=%0d, got st=%0d s=%0d l=%0d d=%0d i=%0d",
                            exp_r.status, $signed(exp_r.station), $signed(exp_r.lateral),
                            exp_r.distance, exp_r.seg, got.status, $signed(got.station),
                            $signed(got.lateral), got.distance, got.seg);
                end
            end
        end
        m_tready <= aresetn && !idle_roll(1'b0);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("polyline_station_lateral_projection_top: mismatch");
            $finish;
        end
    end

    initial begin
        longint cx, cy;
        int k;
        // directed: empty / single-point queries, extremes, unused command
        push_cmd(CMD_PROJECT, 0, 0);
        push_cmd(CMD_APPEND, -8388608, -8388608);
        push_cmd(CMD_PROJECT, 100, 100);
        push_cmd(CMD_APPEND, 8388607, 8388607);
        push_cmd(CMD_PROJECT, -8388608, 8388607);
        push_cmd(CMD_PROJECT, 8388607, -8388608);
        push_cmd(CMD_PROJECT, -8388608, -8388608);
        push_cmd(CMD_PROJECT, 8388607, 8388607);
        push_cmd(2'd3, 8388607, -8388608);
        push_cmd(CMD_CLEAR, 0, 0);
        // tie at a shared vertex, before first and beyond last segment
        push_cmd(CMD_APPEND, 0, 0);
        push_cmd(CMD_APPEND, 256, 0);
        push_cmd(CMD_APPEND, 512, 0);
        push_cmd(CMD_PROJECT, 256, 256);
        push_cmd(CMD_PROJECT, -1000, 300);
        push_cmd(CMD_PROJECT, 2000, -300);
        push_cmd(CMD_PROJECT, 384, -77);
        // zero-length segments
        push_cmd(CMD_APPEND, 512, 0);
        push_cmd(CMD_APPEND, 512, 0);
        push_cmd(CMD_PROJECT, 600, 50);
        push_cmd(CMD_PROJECT, 512, 0);
        // full table
        push_cmd(CMD_CLEAR, 0, 0);
        for (int i = 0; i < NPTS; i++) push_cmd(CMD_APPEND, near(0, 60000), near(0, 60000));
        push_cmd(CMD_APPEND, 5, 5);
        push_cmd(CMD_PROJECT, near(0, 60000), near(0, 60000));
        push_cmd(CMD_CLEAR, 0, 0);

        while (pending_items.size() < 580) begin
            if ($urandom_range(0, 9) == 0) begin
                push_cmd(2'($urandom_range(0, 3)), any_coord(), any_coord());
            end else begin
                push_cmd(CMD_CLEAR, any_coord(), any_coord());
                cx = near(0, 4000000);
                cy = near(0, 4000000);
                k = $urandom_range(2, 8);
                for (int i = 0; i < k; i++) begin
                    if ($urandom_range(0, 9) == 0) push_cmd(CMD_APPEND, any_coord(), any_coord());
                    else push_cmd(CMD_APPEND, near(cx, 40000), near(cy, 40000));
                end
                k = $urandom_range(2, 5);
                for (int i = 0; i < k; i++) begin
                    if ($urandom_range(0, 7) == 0) push_cmd(CMD_PROJECT, any_coord(), any_coord());
                    else push_cmd(CMD_PROJECT, near(cx, 60000), near(cy, 60000));
                end
            end
        end
        total_items = pending_items.size();

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        wait (pending_items.size() == 0 && !s_tvalid);
        wait (expected_results.size() == 0);
        repeat (50) @(posedge aclk);
        if (errors == 0 && expected_results.size() == 0)
            $display("polyline_station_lateral_projection_top: match");
        else
            $display("polyline_station_lateral_projection_top: mismatch");
        $finish;
    end

endmodule
